FILE: rtl/core/thmov_pkg.sv
// Shared constants and types for the Thumb-2 move-immediate encoder.
package thmov_pkg;

    localparam int HW_W     = 16;
    localparam int HW_MAX   = 4;
    localparam int IDX_W    = $clog2(HW_MAX);
    localparam int REG_W    = 4;
    localparam int VAL_W    = 32;
    localparam int FIELD_W  = 12;
    localparam int ROT_W    = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    // Highest bit position at which a rotated 8-bit pattern can start.
    localparam int ROT_POS_MAX = 24;

    localparam logic [HW_W-1:0] OP_MOVS_NARROW = 16'h2000;
    localparam logic [HW_W-1:0] OP_MOVW        = 16'hf240;
    localparam logic [HW_W-1:0] OP_MOVT        = 16'hf2c0;
    localparam logic [HW_W-1:0] OP_MOV_T2      = 16'hf04f;

    // Replicated-pattern selectors in the top bits of a modified immediate.
    localparam logic [3:0] REP_00XY00XY = 4'b0001;
    localparam logic [3:0] REP_XY00XY00 = 4'b0010;
    localparam logic [3:0] REP_XYXYXYXY = 4'b0011;

    // Index of the final halfword for each instruction form.
    localparam logic [IDX_W-1:0] LAST_NARROW = 2'd0;
    localparam logic [IDX_W-1:0] LAST_WIDE   = 2'd1;
    localparam logic [IDX_W-1:0] LAST_PAIR   = 2'd3;

    typedef struct packed {
        logic [HW_MAX-1:0][HW_W-1:0] hw;
        logic [IDX_W-1:0]            last_idx;
    } enc_t;

    // First and second halfword of a MOVW or MOVT for a 16-bit immediate.
    function automatic logic [1:0][HW_W-1:0] wide16(
        input logic [HW_W-1:0]  op,
        input logic [REG_W-1:0] rd,
        input logic [15:0]      imm
    );
        logic [1:0][HW_W-1:0] h;
        h[0] = op | {5'd0, imm[11], 6'd0, imm[15:12]};
        h[1] = {1'b0, imm[10:8], rd, imm[7:0]};
        return h;
    endfunction

endpackage

FILE: rtl/core/thumb_mov_immediate_encoder.sv
// Thumb-2 move-immediate encoder: request register, encoder, halfword output queue.
//
// Each request (destination register, 32-bit constant, set-flags bit) yields the
// Thumb-2 halfwords that load the constant: a narrow MOVS (1 halfword), MOVW or
// MOV T2 (2 halfwords), or a MOVW/MOVT pair (4 halfwords), with m_tlast on the
// final one. The output channel moves one halfword per cycle while m_tready is
// high. A request taken into the request register moves to the output queue
// once the queue is free. The request register in front of the output queue lets
// the next request be taken while the current one drains, so requests follow
// at the pace the output channel sets.
module thumb_mov_immediate_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] dest_reg, [35:4] value, [36] set_flags, [39:37] zero
    input  logic [thmov_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] halfword
    output logic [thmov_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import thmov_pkg::*;

    logic                         in_valid_reg;
    logic [REG_W-1:0]             in_rd_reg;
    logic [VAL_W-1:0]             in_val_reg;
    logic                         in_s_reg;

    logic                         out_valid_reg;
    logic [HW_MAX-1:0][HW_W-1:0]  hw_reg;
    logic [IDX_W-1:0]             left_reg;

    enc_t                         enc;
    logic                         out_take;
    logic                         out_free;
    logic                         load;

    thmov_encode u_encode (
        .dest_reg  (in_rd_reg),
        .value     (in_val_reg),
        .set_flags (in_s_reg),
        .enc       (enc)
    );

    assign out_take = out_valid_reg && m_tready;
    assign out_free = !out_valid_reg || (out_take && left_reg == '0);
    assign load     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_rd_reg  <= s_tdata[3:0];
            in_val_reg <= s_tdata[35:4];
            in_s_reg   <= s_tdata[36];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            left_reg      <= enc.last_idx;
        end else if (out_take) begin
            if (left_reg == '0) begin
                out_valid_reg <= 1'b0;
            end else begin
                left_reg <= left_reg - 1'b1;
            end
        end
    end

    // Load a new request or advance the queue by one halfword.
    always_ff @(posedge aclk) begin
        if (load) begin
            hw_reg <= enc.hw;
        end else if (out_take) begin
            hw_reg <= {HW_W'(0), hw_reg[HW_MAX-1:1]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hw_reg[0];
    assign m_tlast  = (left_reg == '0);

endmodule

FILE: rtl/core/thmov_encode.sv
// Combinational form selection and halfword assembly for one request.
module thmov_encode (
    input  logic [thmov_pkg::REG_W-1:0] dest_reg,
    input  logic [thmov_pkg::VAL_W-1:0] value,
    input  logic                        set_flags,
    output thmov_pkg::enc_t             enc
);
    import thmov_pkg::*;

    logic                   rep_hit;
    logic [FIELD_W-1:0]     rep_f;
    logic                   rot_hit;
    logic [FIELD_W-1:0]     rot_f;
    logic [FIELD_W-1:0]     field;
    logic [1:0][HW_W-1:0]   lo_pair;
    logic [1:0][HW_W-1:0]   hi_pair;

    // Replicated byte patterns: at most one can match a nonzero value.
    always_comb begin
        rep_hit = 1'b1;
        rep_f   = '0;
        if (value[31:24] == 8'd0 && value[15:8] == 8'd0 && value[23:16] == value[7:0]) begin
            rep_f = {REP_00XY00XY, value[7:0]};
        end else if (value[23:16] == 8'd0 && value[7:0] == 8'd0 &&
                     value[31:24] == value[15:8]) begin
            rep_f = {REP_XY00XY00, value[15:8]};
        end else if (value[31:24] == value[7:0] && value[23:16] == value[7:0] &&
                     value[15:8] == value[7:0]) begin
            rep_f = {REP_XYXYXYXY, value[7:0]};
        end else begin
            rep_hit = 1'b0;
        end
    end

    // Rotated form: all set bits sit in one byte window whose top bit is set.
    always_comb begin
        rot_hit = 1'b0;
        rot_f   = '0;
        for (int p = 1; p <= ROT_POS_MAX; p++) begin
            if (((value >> (p + 8)) == '0) && value[p + 7] &&
                ((value << (VAL_W - p)) == '0)) begin
                rot_hit = 1'b1;
                rot_f   = {ROT_W'(VAL_W - p), value[p +: 7]};
            end
        end
    end

    assign field   = rep_hit ? rep_f : rot_f;
    assign lo_pair = wide16(OP_MOVW, dest_reg, value[15:0]);
    assign hi_pair = wide16(OP_MOVT, dest_reg, value[31:16]);

    always_comb begin
        enc.hw       = '0;
        enc.last_idx = LAST_PAIR;
        if (set_flags && !dest_reg[3] && value[31:8] == 24'd0) begin
            enc.hw[0]    = OP_MOVS_NARROW | {5'd0, dest_reg[2:0], value[7:0]};
            enc.last_idx = LAST_NARROW;
        end else if (value[31:16] == 16'd0) begin
            enc.hw[0]    = lo_pair[0];
            enc.hw[1]    = lo_pair[1];
            enc.last_idx = LAST_WIDE;
        end else if (rep_hit || rot_hit) begin
            enc.hw[0]    = OP_MOV_T2 | {5'd0, field[11], 5'd0, set_flags, 4'd0};
            enc.hw[1]    = {1'b0, field[10:8], dest_reg, field[7:0]};
            enc.last_idx = LAST_WIDE;
        end else begin
            enc.hw[0] = lo_pair[0];
            enc.hw[1] = lo_pair[1];
            enc.hw[2] = hi_pair[0];
            enc.hw[3] = hi_pair[1];
        end
    end

endmodule

FILE: rtl/core/thmov_checker.sv
// Port-level checks for the Thumb-2 move-immediate encoder, bound to the top level.
module thmov_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [thmov_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);
    import thmov_pkg::*;

    // A stalled halfword holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output halfword changed while stalled");

    // The rest of a request is already queued once its first halfword leaves.
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a multi-halfword request");

    // A leading halfword of a 32-bit instruction is never the last one.
    a_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> !m_tlast)
        else $error("request ended on a leading halfword");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind thumb_mov_immediate_encoder thmov_checker u_thmov_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: verif/thumb_mov_immediate_encoder_test.sv
// Testbench for the Thumb-2 move-immediate encoder: directed table, random requests, predictor.
`timescale 1ns / 100ps

module thumb_mov_immediate_encoder_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 75;   // per idling phase
    localparam int N_DIRECTED    = 22;
    localparam int DRAIN_CYCLES  = 16;

    // Opcode bases of the instruction forms.
    localparam logic [15:0] MOVS_T1_BASE = 16'h2000;
    localparam logic [15:0] MOVW_T3_BASE = 16'hf240;
    localparam logic [15:0] MOVT_T1_BASE = 16'hf2c0;
    localparam logic [15:0] MOV_T2_BASE  = 16'hf04f;

    // Byte-replication patterns of a modified immediate with top bits zero.
    localparam logic [1:0] PAT_BYTE    = 2'd0;
    localparam logic [1:0] PAT_HALF_LO = 2'd1;
    localparam logic [1:0] PAT_HALF_HI = 2'd2;
    localparam logic [1:0] PAT_ALL     = 2'd3;

    typedef struct packed {
        logic [15:0] hw;
        logic        last;
    } halfword_t;

    // count == 0: take the halfwords from the predictor
    typedef struct packed {
        logic [3:0]  rd;
        logic [31:0] value;
        logic        set_flags;
        logic [2:0]  count;
        logic [63:0] hws;
    } stim_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [thmov_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [thmov_pkg::M_DATA_W-1:0] m_tdata;
    logic                           m_tlast;

    halfword_t expected_halfwords[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        send_idle = 0;
    int        recv_stall = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{4'd0,  32'h0000_0000, 1'b1, 3'd1, 64'h0000_0000_0000_2000},
        '{4'd7,  32'h0000_00ff, 1'b1, 3'd1, 64'h0000_0000_0000_27ff},
        '{4'd0,  32'h0000_0000, 1'b0, 3'd2, 64'h0000_0000_0000_f240},
        '{4'd0,  32'hffff_ffff, 1'b0, 3'd2, 64'h0000_0000_30ff_f04f},
        '{4'd8,  32'h0000_00ff, 1'b1, 3'd0, 64'h0},
        '{4'd15, 32'h0000_ffff, 1'b1, 3'd0, 64'h0},
        '{4'd0,  32'h0000_0100, 1'b1, 3'd0, 64'h0},
        '{4'd13, 32'h0001_0000, 1'b0, 3'd0, 64'h0},
        '{4'd1,  32'hffff_ffff, 1'b1, 3'd0, 64'h0},
        '{4'd2,  32'h00ff_00ff, 1'b1, 3'd0, 64'h0},
        '{4'd3,  32'hff00_ff00, 1'b0, 3'd0, 64'h0},
        '{4'd4,  32'habab_abab, 1'b1, 3'd0, 64'h0},
        '{4'd5,  32'h0100_0100, 1'b0, 3'd0, 64'h0},
        '{4'd6,  32'h8000_0000, 1'b1, 3'd0, 64'h0},
        '{4'd7,  32'h8000_0000, 1'b0, 3'd0, 64'h0},
        '{4'd10, 32'hff00_0000, 1'b1, 3'd0, 64'h0},
        '{4'd12, 32'h0003_fc00, 1'b1, 3'd0, 64'h0},
        '{4'd9,  32'h1234_5678, 1'b1, 3'd0, 64'h0},
        '{4'd14, 32'hffff_0000, 1'b0, 3'd0, 64'h0},
        '{4'd15, 32'h8765_4321, 1'b1, 3'd0, 64'h0},
        '{4'd11, 32'h0001_0001, 1'b1, 3'd0, 64'h0},
        '{4'd13, 32'hffff_fffe, 1'b0, 3'd0, 64'h0}
    };

    thumb_mov_immediate_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic logic [31:0] expand_mod_imm(input logic [11:0] f);
        logic [7:0]  b;
        logic [7:0]  v;
        logic [63:0] dbl;
        b = f[7:0];
        if (f[11:10] == 2'b00) begin
            case (f[9:8])
                PAT_BYTE:    return {24'd0, b};
                PAT_HALF_LO: return {8'd0, b, 8'd0, b};
                PAT_HALF_HI: return {b, 8'd0, b, 8'd0};
                default:     return {b, b, b, b};
            endcase
        end
        // rotate 1bcdefgh right by the top five bits
        v = {1'b1, f[6:0]};
        dbl = {24'd0, v, 24'd0, v} >> f[11:7];
        return dbl[31:0];
    endfunction

    // {second, first} halfword of a MOVW/MOVT carrying a 16-bit immediate
    function automatic logic [31:0] wide_move(input logic [15:0] op, input logic [3:0] rd,
                                              input logic [15:0] imm);
        logic [15:0] first;
        logic [15:0] second;
        first = op | (16'(imm[11]) << 10) | 16'(imm[15:12]);
        second = (16'(imm[10:8]) << 12) | (16'(rd) << 8) | 16'(imm[7:0]);
        return {second, first};
    endfunction

    function automatic int encode_mov_imm(input logic [3:0] rd, input logic [31:0] v,
                                          input logic s, output logic [63:0] hws);
        logic        found;
        logic [11:0] hit;
        int          k;
        hws = '0;
        found = 1'b0;
        hit = '0;
        if (s && rd < 4'd8 && v <= 32'hff) begin
            hws[15:0] = MOVS_T1_BASE | (16'(rd) << 8) | 16'(v[7:0]);
            return 1;
        end
        if (v <= 32'hffff) begin
            hws[31:0] = wide_move(MOVW_T3_BASE, rd, v[15:0]);
            return 2;
        end
        // lowest field wins
        for (k = 0; k < 4096 && !found; k++) begin
            if (expand_mod_imm(k[11:0]) == v) begin
                found = 1'b1;
                hit = k[11:0];
            end
        end
        if (found) begin
            hws[15:0] = MOV_T2_BASE | (16'(hit[11]) << 10) | (16'(s) << 4);
            hws[31:16] = (16'(hit[10:8]) << 12) | (16'(rd) << 8) | 16'(hit[7:0]);
            return 2;
        end
        hws = {wide_move(MOVT_T1_BASE, rd, v[31:16]), wide_move(MOVW_T3_BASE, rd, v[15:0])};
        return 4;
    endfunction

    // Queue the expected halfwords, present the request and hold it until taken.
    task automatic send_request(input logic [3:0] rd, input logic [31:0] v, input logic s,
                                input int count, input logic [63:0] typed_hws);
        logic [63:0] hws;
        int          n;
        int          k;
        hws = typed_hws;
        n = count;
        if (n == 0) n = encode_mov_imm(rd, v, s, hws);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        for (k = 0; k < n; k++)
            expected_halfwords.push_back('{hw: hws[16*k +: 16], last: (k == n - 1)});
        s_tvalid <= 1'b1;
        s_tdata <= {3'd0, s, v, rd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        halfword_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_halfwords.size() == 0) begin
                $display("%0t: unexpected halfword %h last %b", $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = expected_halfwords.pop_front();
                if (m_tdata !== want.hw || m_tlast !== want.last) begin
                    $display("%0t: expected halfword %h last %b, got %h last %b",
                             $time, want.hw, want.last, m_tdata, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("thumb_mov_immediate_encoder test failed");
            $finish;
        end
    end

    initial begin
        int          i;
        int          phase;
        int          kind;
        logic [3:0]  rd;
        logic [31:0] v;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_DIRECTED; i++)
            send_request(directed_rows[i].rd, directed_rows[i].value,
                         directed_rows[i].set_flags, directed_rows[i].count,
                         directed_rows[i].hws);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 61; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 61; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            for (i = 0; i < RANDOM_ITEMS; i++) begin
                rd = 4'($urandom_range(0, 15));
                kind = $urandom_range(0, 9);
                if (kind < 2)      v = $urandom_range(0, 255);
                else if (kind < 4) v = $urandom_range(0, 65535);
                else if (kind < 7) v = expand_mod_imm(12'($urandom_range(0, 4095)));
                else               v = $urandom;
                send_request(rd, v, 1'($urandom_range(0, 1)), 0, 64'h0);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_halfwords.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("thumb_mov_immediate_encoder test passed");
        end else begin
            $display("thumb_mov_immediate_encoder test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/thmov_pkg.sv
rtl/core/thmov_encode.sv
rtl/core/thumb_mov_immediate_encoder.sv
rtl/core/thmov_checker.sv
verif/thumb_mov_immediate_encoder_test.sv
